/* rtl/icmp_ht_pkg.sv */
// ----------------------------------------------------------------------------
// ICMP header translator package
// Shared types, message codes and the parameter problem pointer table.
// ----------------------------------------------------------------------------
`default_nettype none

package icmp_ht_pkg;

  // Direction of translation.
  localparam logic CMD_V6_TO_V4 = 1'b0;
  localparam logic CMD_V4_TO_V6 = 1'b1;

  // ICMPv6 message types.
  localparam logic [7:0] V6_DST_UNREACH   = 8'd1;
  localparam logic [7:0] V6_TOO_BIG       = 8'd2;
  localparam logic [7:0] V6_TIME_EXCEEDED = 8'd3;
  localparam logic [7:0] V6_PARAM_PROB    = 8'd4;
  localparam logic [7:0] V6_ECHO_REQ      = 8'd128;
  localparam logic [7:0] V6_ECHO_REP      = 8'd129;
  localparam logic [7:0] V6_MLD_QUERY     = 8'd130;
  localparam logic [7:0] V6_MLD_REPORT    = 8'd131;
  localparam logic [7:0] V6_MLD_DONE      = 8'd132;
  localparam logic [7:0] V6_ROUTER_SOL    = 8'd133;
  localparam logic [7:0] V6_REDIRECT      = 8'd137;

  // ICMPv4 message types.
  localparam logic [7:0] V4_ECHO_REP      = 8'd0;
  localparam logic [7:0] V4_DST_UNREACH   = 8'd3;
  localparam logic [7:0] V4_ECHO_REQ      = 8'd8;
  localparam logic [7:0] V4_TIME_EXCEEDED = 8'd11;
  localparam logic [7:0] V4_PARAM_PROB    = 8'd12;

  // ICMPv6 codes of interest.
  localparam logic [7:0] V6U_NO_ROUTE     = 8'd0;
  localparam logic [7:0] V6U_ADMIN        = 8'd1;
  localparam logic [7:0] V6U_BEYOND_SCOPE = 8'd2;
  localparam logic [7:0] V6U_ADDR         = 8'd3;
  localparam logic [7:0] V6U_PORT         = 8'd4;
  localparam logic [7:0] V6P_HDR_FIELD    = 8'd0;
  localparam logic [7:0] V6P_NEXT_HDR     = 8'd1;
  localparam logic [7:0] V6P_OPTION       = 8'd2;

  // ICMPv4 codes produced.
  localparam logic [7:0] V4C_ZERO         = 8'd0;
  localparam logic [7:0] V4U_HOST         = 8'd1;
  localparam logic [7:0] V4U_PROTOCOL     = 8'd2;
  localparam logic [7:0] V4U_PORT         = 8'd3;
  localparam logic [7:0] V4U_FRAG_NEEDED  = 8'd4;
  localparam logic [7:0] V4U_HOST_ADMIN   = 8'd10;

  // Pointer to the protocol field of the IPv4 header.
  localparam logic [7:0] V4_PTR_PROTOCOL  = 8'd9;

  // Smallest IPv6 link MTU, reported for packet too big.
  localparam logic [15:0] MIN_MTU         = 16'd1280;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_TYPE    = 3'd1,
    ST_BAD_UNREACH = 3'd2,
    ST_BAD_PARAM   = 3'd3,
    ST_MLD         = 3'd4,
    ST_ND          = 3'd5
  } status_e;

  typedef struct packed {
    logic        command;
    logic [7:0]  in_type;
    logic [7:0]  in_code;
    logic [15:0] ident;
    logic [15:0] sequence_req;
    logic [7:0]  pointer;
  } req_t;

  typedef struct packed {
    logic [7:0]  out_type;
    logic [7:0]  out_code;
    logic [31:0] rest_word;
    status_e     status;
  } res_t;

  // Maps an IPv6 header byte offset to the matching IPv4 header offset.
  function automatic logic [7:0] map_pointer(input logic [7:0] p);
    logic [7:0] r;
    case (p) inside
      8'd0:         r = 8'd0;
      8'd1:         r = 8'd1;
      8'd4, 8'd5:   r = 8'd2;
      8'd6:         r = 8'd9;
      8'd7:         r = 8'd8;
      [8'd8:8'd23]: r = 8'd12;
      [8'd24:8'd39]: r = 8'd16;
      default:      r = 8'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/icmp_header_translator_core.sv */
// ----------------------------------------------------------------------------
// ICMP header translator core
// Rewrites ICMP headers between IPv6 and IPv4 forms, one header per cycle.
// ----------------------------------------------------------------------------
// Usage:
// A header word is presented on command_i, in_type_i, in_code_i, ident_i,
// sequence_req_i and pointer_i together with start. It is taken at the rising
// edge where start is high and busy is low. The block never holds a word off,
// so busy is tied low and a new word may be started in every cycle.
// The word is first captured in an input register; the translation is a
// shallow decode that runs between that register and the result register.
// The translated header appears on out_type_o, out_code_o, rest_word_o and
// status_o once the word has passed the result register, marked by done_o for
// exactly one cycle, and is taken at the edge that ends that cycle.
// Throughput is one word per cycle, and words leave in the order they arrived.
// The receiver cannot stall: each result must be consumed in its cycle.
// A status other than ok means the message is refused; the header fields are
// then all zero. Reset clears both valid flags, so no stale result appears
// after reset; the payload registers are left uncleared.
// ----------------------------------------------------------------------------
`default_nettype none

module icmp_header_translator_core
  import icmp_ht_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        command_i,
  input  logic [7:0]  in_type_i,
  input  logic [7:0]  in_code_i,
  input  logic [15:0] ident_i,
  input  logic [15:0] sequence_req_i,
  input  logic [7:0]  pointer_i,
  output logic        done_o,
  output logic [7:0]  out_type_o,
  output logic [7:0]  out_code_o,
  output logic [31:0] rest_word_o,
  output logic [2:0]  status_o
);

  logic accept;
  logic in_valid_q;
  req_t req_d, req_q;
  logic out_valid_q;
  res_t res_d, res_q;

  // The pipeline has no back-pressure, so the block is always ready.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign req_d = '{
    command:      command_i,
    in_type:      in_type_i,
    in_code:      in_code_i,
    ident:        ident_i,
    sequence_req: sequence_req_i,
    pointer:      pointer_i
  };

  // Valid flags are the only control state and are cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= accept;
      out_valid_q <= in_valid_q;
    end
  end

  // Payload registers load only when a word moves into them.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_d;
    end
    if (in_valid_q) begin
      res_q <= res_d;
    end
  end

  icmp_ht_xlate u_xlate (
    .req_i (req_q),
    .res_o (res_d)
  );

  assign done_o      = out_valid_q;
  assign out_type_o  = res_q.out_type;
  assign out_code_o  = res_q.out_code;
  assign rest_word_o = res_q.rest_word;
  assign status_o    = res_q.status;

`ifndef SYNTH
  // Every accepted word yields a result once it has passed both registers.
  a_accept_to_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##1 done_o)
    else $error("accepted word did not produce a result");

  // No result appears without a matching accepted word.
  a_done_has_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 2))
    else $error("result strobe without an accepted word");

  // A refused message must carry an all-zero header.
  a_refused_is_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |->
      (out_type_o == 8'd0 && out_code_o == 8'd0 && rest_word_o == 32'd0))
    else $error("refused message carries header content");
`endif

endmodule

`default_nettype wire

/* rtl/icmp_ht_xlate.sv */
// ----------------------------------------------------------------------------
// ICMP header translator decode
// Combinational rewrite of one header word between ICMPv6 and ICMPv4 forms.
// ----------------------------------------------------------------------------
`default_nettype none

module icmp_ht_xlate
  import icmp_ht_pkg::*;
(
  input  req_t req_i,
  output res_t res_o
);

  logic [31:0] echo_word;
  res_t        res;

  assign echo_word = {req_i.ident, req_i.sequence_req};

  always_comb begin
    res.out_type  = 8'd0;
    res.out_code  = V4C_ZERO;
    res.rest_word = 32'd0;
    res.status    = ST_OK;

    if (req_i.command == CMD_V6_TO_V4) begin
      unique case (req_i.in_type) inside
        V6_ECHO_REQ: begin
          res.out_type  = V4_ECHO_REQ;
          res.rest_word = echo_word;
        end
        V6_ECHO_REP: begin
          res.out_type  = V4_ECHO_REP;
          res.rest_word = echo_word;
        end
        V6_DST_UNREACH: begin
          res.out_type = V4_DST_UNREACH;
          case (req_i.in_code) inside
            V6U_NO_ROUTE, V6U_BEYOND_SCOPE, V6U_ADDR: res.out_code = V4U_HOST;
            V6U_PORT:  res.out_code = V4U_PORT;
            V6U_ADMIN: res.out_code = V4U_HOST_ADMIN;
            default:   res.status   = ST_BAD_UNREACH;
          endcase
        end
        V6_PARAM_PROB: begin
          case (req_i.in_code) inside
            V6P_NEXT_HDR: begin
              res.out_type  = V4_DST_UNREACH;
              res.out_code  = V4U_PROTOCOL;
              res.rest_word = {V4_PTR_PROTOCOL, 24'd0};
            end
            V6P_HDR_FIELD, V6P_OPTION: begin
              res.out_type  = V4_PARAM_PROB;
              res.rest_word = {map_pointer(req_i.pointer), 24'd0};
            end
            default: res.status = ST_BAD_PARAM;
          endcase
        end
        V6_TOO_BIG: begin
          res.out_type  = V4_DST_UNREACH;
          res.out_code  = V4U_FRAG_NEEDED;
          res.rest_word = {16'd0, MIN_MTU};
        end
        V6_TIME_EXCEEDED: res.out_type = V4_TIME_EXCEEDED;
        V6_MLD_QUERY, V6_MLD_REPORT, V6_MLD_DONE: res.status = ST_MLD;
        V6_ROUTER_SOL, V6_REDIRECT: res.status = ST_ND;
        default: res.status = ST_BAD_TYPE;
      endcase
    end else begin
      unique case (req_i.in_type) inside
        V4_ECHO_REQ: begin
          res.out_type  = V6_ECHO_REQ;
          res.rest_word = echo_word;
        end
        V4_ECHO_REP: begin
          res.out_type  = V6_ECHO_REP;
          res.rest_word = echo_word;
        end
        default: res.status = ST_BAD_TYPE;
      endcase
    end

    // A refused message carries no header content.
    if (res.status != ST_OK) begin
      res.out_type  = 8'd0;
      res.out_code  = 8'd0;
      res.rest_word = 32'd0;
    end
  end

  assign res_o = res;

endmodule

`default_nettype wire

/* test/tb.sv */
// ----------------------------------------------------------------------------
// ICMP header translator core testbench
// Sends ICMP header words in both directions: a directed set first, then
// weighted random traffic. Each accepted word is translated by a local
// predictor and the expected header is queued. Every result strobe is checked
// field by field against the oldest queued header.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import icmp_ht_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // This bound only catches a hang.
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_WORDS = 1125;
  // The core returns each result through an input and a result register.
  localparam int unsigned SETTLE_CYCLES = 6;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        command_i;
  logic [7:0]  in_type_i;
  logic [7:0]  in_code_i;
  logic [15:0] ident_i;
  logic [15:0] sequence_req_i;
  logic [7:0]  pointer_i;
  logic        done_o;
  logic [7:0]  out_type_o;
  logic [7:0]  out_code_o;
  logic [31:0] rest_word_o;
  logic [2:0]  status_o;

  // Translated headers still owed by the core, oldest first.
  res_t        pending_headers[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  // Words left in the sender's current burst before it takes a gap.
  int unsigned burst_left  = 0;

  icmp_header_translator_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .command_i      (command_i),
    .in_type_i      (in_type_i),
    .in_code_i      (in_code_i),
    .ident_i        (ident_i),
    .sequence_req_i (sequence_req_i),
    .pointer_i      (pointer_i),
    .done_o         (done_o),
    .out_type_o     (out_type_o),
    .out_code_o     (out_code_o),
    .rest_word_o    (rest_word_o),
    .status_o       (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor: the translated header that one input word should produce.
  // --------------------------------------------------------------------------
  function automatic res_t translate_header(input req_t w);
    res_t        r;
    logic [7:0]  v4_offset;
    logic [31:0] echo_word;
    r         = '0;
    r.status  = ST_OK;
    echo_word = {w.ident, w.sequence_req};

    // IPv6 header byte offsets map onto the matching IPv4 header offsets.
    // Offsets with no IPv4 counterpart fall back to zero, still with status ok.
    if (w.pointer == 8'd0) v4_offset = 8'd0;
    else if (w.pointer == 8'd1) v4_offset = 8'd1;
    else if (w.pointer == 8'd4 || w.pointer == 8'd5) v4_offset = 8'd2;
    else if (w.pointer == 8'd6) v4_offset = 8'd9;
    else if (w.pointer == 8'd7) v4_offset = 8'd8;
    else if (w.pointer >= 8'd8 && w.pointer <= 8'd23) v4_offset = 8'd12;
    else if (w.pointer >= 8'd24 && w.pointer <= 8'd39) v4_offset = 8'd16;
    else v4_offset = 8'd0;

    if (w.command == CMD_V6_TO_V4) begin
      case (w.in_type)
        V6_ECHO_REQ: begin
          r.out_type  = V4_ECHO_REQ;
          r.rest_word = echo_word;
        end
        V6_ECHO_REP: begin
          r.out_type  = V4_ECHO_REP;
          r.rest_word = echo_word;
        end
        V6_DST_UNREACH: begin
          r.out_type = V4_DST_UNREACH;
          case (w.in_code)
            V6U_NO_ROUTE, V6U_BEYOND_SCOPE, V6U_ADDR: r.out_code = V4U_HOST;
            V6U_PORT:  r.out_code = V4U_PORT;
            V6U_ADMIN: r.out_code = V4U_HOST_ADMIN;
            default:   r.status   = ST_BAD_UNREACH;
          endcase
        end
        V6_PARAM_PROB: begin
          case (w.in_code)
            V6P_NEXT_HDR: begin
              // An unknown next header becomes protocol unreachable, with
              // the pointer aimed at the IPv4 protocol field.
              r.out_type  = V4_DST_UNREACH;
              r.out_code  = V4U_PROTOCOL;
              r.rest_word = {V4_PTR_PROTOCOL, 24'h0};
            end
            V6P_HDR_FIELD, V6P_OPTION: begin
              r.out_type  = V4_PARAM_PROB;
              r.out_code  = V4C_ZERO;
              r.rest_word = {v4_offset, 24'h0};
            end
            default: r.status = ST_BAD_PARAM;
          endcase
        end
        V6_TOO_BIG: begin
          r.out_type  = V4_DST_UNREACH;
          r.out_code  = V4U_FRAG_NEEDED;
          r.rest_word = {16'h0, MIN_MTU};
        end
        V6_TIME_EXCEEDED: r.out_type = V4_TIME_EXCEEDED;
        V6_MLD_QUERY, V6_MLD_REPORT, V6_MLD_DONE: r.status = ST_MLD;
        V6_ROUTER_SOL, V6_REDIRECT: r.status = ST_ND;
        default: r.status = ST_BAD_TYPE;
      endcase
    end else begin
      if (w.in_type == V4_ECHO_REQ) begin
        r.out_type  = V6_ECHO_REQ;
        r.rest_word = echo_word;
      end else if (w.in_type == V4_ECHO_REP) begin
        r.out_type  = V6_ECHO_REP;
        r.rest_word = echo_word;
      end else begin
        r.status = ST_BAD_TYPE;
      end
    end

    // A refused message carries an all-zero header.
    if (r.status != ST_OK) begin
      r.out_type  = '0;
      r.out_code  = '0;
      r.rest_word = '0;
    end
    return r;
  endfunction

  function automatic req_t make_header(input logic cmd, input logic [7:0] typ,
                                       input logic [7:0] code, input logic [15:0] id,
                                       input logic [15:0] seq, input logic [7:0] ptr);
    req_t w;
    w.command      = cmd;
    w.in_type      = typ;
    w.in_code      = code;
    w.ident        = id;
    w.sequence_req = seq;
    w.pointer      = ptr;
    return w;
  endfunction

  // Random header, weighted towards types the core translates so that most
  // words get past the type decode; the rest are refused types or arbitrary bytes.
  function automatic req_t random_header();
    req_t        w;
    logic [31:0] raw;
    logic [31:0] pick;
    logic [31:0] val;
    raw            = $urandom;
    w.ident        = raw[15:0];
    w.sequence_req = raw[31:16];
    raw            = $urandom;
    w.command      = ($urandom_range(0, 3) == 0) ? CMD_V4_TO_V6 : CMD_V6_TO_V4;

    // Pointers mostly land in and just past the mapped offset range.
    val       = $urandom_range(0, 47);
    w.pointer = ($urandom_range(0, 3) != 0) ? val[7:0] : raw[7:0];
    // Codes mostly small, so that the code tables are well covered.
    val       = $urandom_range(0, 5);
    w.in_code = ($urandom_range(0, 3) != 0) ? val[7:0] : raw[15:8];

    pick = $urandom_range(0, 15);
    if (w.command == CMD_V4_TO_V6) begin
      if (pick < 6) w.in_type = V4_ECHO_REQ;
      else if (pick < 12) w.in_type = V4_ECHO_REP;
      else if (pick == 12) w.in_type = V4_DST_UNREACH;
      else w.in_type = raw[23:16];
    end else begin
      case (pick)
        0, 1:    w.in_type = V6_ECHO_REQ;
        2, 3:    w.in_type = V6_ECHO_REP;
        4, 5:    w.in_type = V6_DST_UNREACH;
        6, 7:    w.in_type = V6_PARAM_PROB;
        8:       w.in_type = V6_TOO_BIG;
        9:       w.in_type = V6_TIME_EXCEEDED;
        10: begin
          val       = $urandom_range(0, 2);
          w.in_type = V6_MLD_QUERY + val[7:0];
        end
        11:      w.in_type = raw[24] ? V6_ROUTER_SOL : V6_REDIRECT;
        default: w.in_type = raw[23:16];
      endcase
    end
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Sender. Start stays high through a burst; between most bursts it drops for a
  // random gap so that gaps fall on every stage of the pipeline.
  // --------------------------------------------------------------------------
  task automatic send_word(input req_t w);
    int unsigned gap;
    start          <= 1'b1;
    command_i      <= w.command;
    in_type_i      <= w.in_type;
    in_code_i      <= w.in_code;
    ident_i        <= w.ident;
    sequence_req_i <= w.sequence_req;
    pointer_i      <= w.pointer;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    if (burst_left == 0) begin
      // Long bursts with no gap at all happen as well.
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end else begin
      burst_left--;
    end
  endtask

  // Hold the sender off until the core has returned every outstanding word.
  // The first edge lets the checker record a word accepted at the last edge.
  task automatic wait_for_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_headers.size() != 0) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Test cases.
  // --------------------------------------------------------------------------
  task automatic test_echo();
    // Identifier and sequence number at their extremes, both ways round.
    send_word(make_header(CMD_V6_TO_V4, V6_ECHO_REQ, 8'h00, 16'hffff, 16'h0000, 8'hff));
    send_word(make_header(CMD_V6_TO_V4, V6_ECHO_REP, 8'hff, 16'h0000, 16'hffff, 8'h00));
    send_word(make_header(CMD_V4_TO_V6, V4_ECHO_REQ, 8'h00, 16'hffff, 16'hffff, 8'h00));
    send_word(make_header(CMD_V4_TO_V6, V4_ECHO_REP, 8'hff, 16'h0000, 16'h0000, 8'hff));
  endtask

  task automatic test_unreachable();
    // Every defined code, then the first undefined one and the largest.
    send_word(make_header(CMD_V6_TO_V4, V6_DST_UNREACH, V6U_NO_ROUTE, 16'h1234, 16'h5678,
                          8'h00));
    send_word(make_header(CMD_V6_TO_V4, V6_DST_UNREACH, V6U_ADMIN, 16'h0, 16'h0, 8'h00));
    send_word(make_header(CMD_V6_TO_V4, V6_DST_UNREACH, V6U_BEYOND_SCOPE, 16'h0, 16'h0,
                          8'h00));
    send_word(make_header(CMD_V6_TO_V4, V6_DST_UNREACH, V6U_ADDR, 16'h0, 16'h0, 8'h00));
    send_word(make_header(CMD_V6_TO_V4, V6_DST_UNREACH, V6U_PORT, 16'h0, 16'h0, 8'h00));
    send_word(make_header(CMD_V6_TO_V4, V6_DST_UNREACH, 8'd5, 16'h0, 16'h0, 8'h00));
    send_word(make_header(CMD_V6_TO_V4, V6_DST_UNREACH, 8'hff, 16'hffff, 16'hffff,
                          8'hff));
  endtask

  task automatic test_param_problem();
    // Unknown next header, a mapped offset, the top of the mapped range, an
    // offset with no IPv4 counterpart, and an undefined code.
    send_word(make_header(CMD_V6_TO_V4, V6_PARAM_PROB, V6P_NEXT_HDR, 16'h0, 16'h0, 8'd20));
    send_word(make_header(CMD_V6_TO_V4, V6_PARAM_PROB, V6P_HDR_FIELD, 16'h0, 16'h0, 8'd6));
    send_word(make_header(CMD_V6_TO_V4, V6_PARAM_PROB, V6P_OPTION, 16'h0, 16'h0, 8'd39));
    send_word(make_header(CMD_V6_TO_V4, V6_PARAM_PROB, V6P_HDR_FIELD, 16'h0, 16'h0,
                          8'hff));
    send_word(make_header(CMD_V6_TO_V4, V6_PARAM_PROB, 8'd3, 16'h0, 16'h0, 8'd7));
  endtask

  task automatic test_other_v6_types();
    send_word(make_header(CMD_V6_TO_V4, V6_TOO_BIG, 8'h00, 16'hffff, 16'hffff, 8'hff));
    send_word(make_header(CMD_V6_TO_V4, V6_TIME_EXCEEDED, 8'h01, 16'h0, 16'h0, 8'h00));
    // MLD and neighbour discovery messages are refused with their own status.
    send_word(make_header(CMD_V6_TO_V4, V6_MLD_QUERY, 8'h00, 16'h0, 16'h0, 8'h00));
    send_word(make_header(CMD_V6_TO_V4, V6_ROUTER_SOL, 8'h00, 16'h0, 16'h0, 8'h00));
    send_word(make_header(CMD_V6_TO_V4, V6_REDIRECT, 8'h00, 16'h0, 16'h0, 8'h00));
    // Type bytes at both ends of the range, neither of them translated.
    send_word(make_header(CMD_V6_TO_V4, 8'h00, 8'h00, 16'h0, 16'h0, 8'h00));
    send_word(make_header(CMD_V6_TO_V4, 8'hff, 8'hff, 16'hffff, 16'hffff, 8'hff));
  endtask

  task automatic test_v4_refused();
    // Only echo crosses from IPv4 to IPv6; everything else is refused.
    send_word(make_header(CMD_V4_TO_V6, V4_DST_UNREACH, 8'h01, 16'h0, 16'h0, 8'h00));
    send_word(make_header(CMD_V4_TO_V6, 8'hff, 8'hff, 16'hffff, 16'hffff, 8'hff));
  endtask

  task automatic test_random_traffic(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_word(random_header());
      // Now and then let the pipeline run completely dry.
      if (i % 400 == 399) wait_for_results();
    end
  endtask

  // --------------------------------------------------------------------------
  // Result checking. One always block both retires results and records newly
  // accepted words, so the order of the two is fixed.
  // --------------------------------------------------------------------------
  task automatic report_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    res_t want;
    req_t word;
    if (rst_ni) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("%0t ns: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
        $display("FAIL");
        $finish;
      end else begin
        if (done_o === 1'b1) begin
          if (pending_headers.size() == 0) begin
            $display("%0t ns: result strobe with no word outstanding", $time);
            error_count++;
          end else begin
            want = pending_headers.pop_front();
            report_field("out_type", {24'h0, want.out_type}, {24'h0, out_type_o});
            report_field("out_code", {24'h0, want.out_code}, {24'h0, out_code_o});
            report_field("rest_word", want.rest_word, rest_word_o);
            report_field("status", {29'h0, want.status}, {29'h0, status_o});
          end
        end
        if (start && busy === 1'b0) begin
          word = make_header(command_i, in_type_i, in_code_i, ident_i, sequence_req_i,
                             pointer_i);
          pending_headers.push_back(translate_header(word));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    rst_ni         <= 1'b0;
    start          <= 1'b0;
    command_i      <= CMD_V6_TO_V4;
    in_type_i      <= '0;
    in_code_i      <= '0;
    ident_i        <= '0;
    sequence_req_i <= '0;
    pointer_i      <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_echo();
    test_unreachable();
    test_param_problem();
    test_other_v6_types();
    test_v4_refused();
    wait_for_results();
    test_random_traffic(RANDOM_WORDS);

    // Drain, then wait SETTLE_CYCLES more in case a stray result follows.
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_headers.size() != 0) begin
      $display("%0t ns: %0d results never arrived, expected 0, actual %0d", $time,
               pending_headers.size(), pending_headers.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
